// ===== sv/hp_pkg.sv =====
package hp_pkg;

  localparam int FIELD_W = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POLL   = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_NONE   = 2'd3
  } hp_mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } hp_status_t;

  typedef struct packed {
    hp_status_t          status;
    logic [FIELD_W-1:0]  out_key;
    logic [FIELD_W-1:0]  out_value;
    logic [6:0]          entry_count;
    logic                top_valid;
    logic [FIELD_W-1:0]  top_key;
    logic [FIELD_W-1:0]  top_value;
  } hp_result_t;

endpackage

// ===== sv/hp_ram.sv =====
module hp_ram import hp_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32,
  parameter int AW        = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [KEY_WIDTH-1:0] wkey,
  input  logic [FIELD_W-1:0]   wval,
  input  logic [AW-1:0]        raddr,
  output logic [KEY_WIDTH-1:0] rkey,
  output logic [FIELD_W-1:0]   rval
);

  logic [KEY_WIDTH-1:0] key_mem [CAPACITY];
  logic [FIELD_W-1:0]   val_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule

// ===== sv/hp_ctrl.sv =====
module hp_ctrl import hp_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32,
  parameter int AW        = $clog2(CAPACITY),
  parameter int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 min_first,
  input  logic                 start,
  output logic                 ready,
  input  hp_mode_t             mode,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [FIELD_W-1:0]   value,
  input  logic [5:0]           position,
  output logic                 we,
  output logic [AW-1:0]        waddr,
  output logic [KEY_WIDTH-1:0] wkey,
  output logic [FIELD_W-1:0]   wval,
  output logic [AW-1:0]        raddr,
  input  logic [KEY_WIDTH-1:0] rkey,
  input  logic [FIELD_W-1:0]   rval,
  output logic                 res_valid,
  input  logic                 res_take,
  output hp_result_t           res
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_UP_CHK = 10'b00_0000_0010,
    S_UP_CMP = 10'b00_0000_0100,
    S_UPD_LD = 10'b00_0000_1000,
    S_DN_LD  = 10'b00_0001_0000,
    S_DN_CHK = 10'b00_0010_0000,
    S_DN_RL  = 10'b00_0100_0000,
    S_DN_RR  = 10'b00_1000_0000,
    S_DN_SW  = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        pos;
  logic [KEY_WIDTH-1:0] cur_key;
  logic [FIELD_W-1:0]   cur_val;
  logic [KEY_WIDTH-1:0] lkey;
  logic [FIELD_W-1:0]   lval;
  logic [KEY_WIDTH-1:0] pick_key;
  logic [FIELD_W-1:0]   pick_val;
  logic [AW-1:0]        pick_idx;
  hp_status_t           status;
  logic [FIELD_W-1:0]   out_key;
  logic [FIELD_W-1:0]   out_val;
  logic [KEY_WIDTH-1:0] top_key;
  logic [FIELD_W-1:0]   top_val;

  // shared compare unit
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 better;

  always_comb begin
    case (state)
      S_DN_RR: begin
        cmp_a = rkey;
        cmp_b = lkey;
      end
      S_DN_SW: begin
        cmp_a = pick_key;
        cmp_b = cur_key;
      end
      default: begin
        cmp_a = cur_key;
        cmp_b = rkey;
      end
    endcase
    better = min_first ? (cmp_a < cmp_b) : (cmp_a > cmp_b);
  end

  // index arithmetic
  logic [AW-1:0]         parent;
  logic [AW:0]           pos_m1;
  logic [AW+1:0]         lwide, rwide, cnt_w;
  logic                  l_in, r_in;
  logic [CW-1:0]         cnt_m1;
  logic [CW+5:0]         pos_ext, cnt_ext;
  logic                  pos_oob;
  logic [AW-1:0]         pos_addr;
  logic [KEY_WIDTH+31:0] top_key_ext;
  logic [CW+6:0]         cnt7_ext;

  assign pos_m1   = {1'b0, pos} - 1'b1;
  assign parent   = pos_m1[AW:1];
  assign lwide    = {1'b0, pos, 1'b1};
  assign rwide    = lwide + 1'b1;
  assign cnt_w    = (AW+2)'(count);
  assign l_in     = lwide < cnt_w;
  assign r_in     = rwide < cnt_w;
  assign cnt_m1   = count - 1'b1;
  assign pos_ext  = {{CW{1'b0}}, position};
  assign cnt_ext  = {6'b0, count};
  assign pos_oob  = pos_ext >= cnt_ext;
  assign pos_addr = AW'(position);

  assign ready = (state == S_IDLE);

  // memory port
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wkey  = cur_key;
    wval  = cur_val;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (mode == MODE_UPDATE) raddr = pos_addr;
        else raddr = AW'(cnt_m1);
      end
      S_UP_CHK: begin
        if (pos == '0) we = 1'b1;
        else raddr = parent;
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (better) begin
          wkey = rkey;
          wval = rval;
        end
      end
      S_DN_CHK: begin
        if (!l_in) we = 1'b1;
        else raddr = lwide[AW-1:0];
      end
      S_DN_RL: begin
        if (r_in) raddr = rwide[AW-1:0];
      end
      S_DN_SW: begin
        we = 1'b1;
        if (better) begin
          wkey = pick_key;
          wval = pick_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            status  <= ST_OK;
            out_key <= '0;
            out_val <= '0;
            case (mode)
              MODE_INSERT: begin
                if (count >= CW'(CAPACITY)) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else begin
                  pos     <= AW'(count);
                  cur_key <= key;
                  cur_val <= value;
                  count   <= count + 1'b1;
                  state   <= S_UP_CHK;
                end
              end
              MODE_POLL: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_DONE;
                end else begin
                  out_key <= top_key_ext[31:0];
                  out_val <= top_val;
                  count   <= cnt_m1;
                  state   <= (cnt_m1 == '0) ? S_DONE : S_DN_LD;
                end
              end
              MODE_UPDATE: begin
                if (pos_oob) begin
                  status <= ST_RANGE;
                  state  <= S_DONE;
                end else begin
                  pos     <= pos_addr;
                  cur_key <= key;
                  state   <= S_UPD_LD;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_UPD_LD: begin
          cur_val <= rval;
          state   <= S_UP_CHK;
        end
        S_UP_CHK: begin
          state <= (pos == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (better) begin
            pos   <= parent;
            state <= S_UP_CHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_LD: begin
          cur_key <= rkey;
          cur_val <= rval;
          pos     <= '0;
          state   <= S_DN_CHK;
        end
        S_DN_CHK: begin
          state <= l_in ? S_DN_RL : S_DONE;
        end
        S_DN_RL: begin
          lkey  <= rkey;
          lval  <= rval;
          state <= S_DN_RR;
        end
        S_DN_RR: begin
          // left child wins a tie
          if (r_in && better) begin
            pick_key <= rkey;
            pick_val <= rval;
            pick_idx <= rwide[AW-1:0];
          end else begin
            pick_key <= lkey;
            pick_val <= lval;
            pick_idx <= lwide[AW-1:0];
          end
          state <= S_DN_SW;
        end
        S_DN_SW: begin
          if (better) begin
            pos   <= pick_idx;
            state <= S_DN_CHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // copy of the root entry, kept in step with every write to the root slot
  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      top_key <= wkey;
      top_val <= wval;
    end
  end

  assign top_key_ext = {32'b0, top_key};
  assign cnt7_ext    = {7'b0, count};
  assign res_valid   = (state == S_DONE);

  always_comb begin
    res.status      = status;
    res.out_key     = out_key;
    res.out_value   = out_val;
    res.entry_count = cnt7_ext[6:0];
    res.top_valid   = (count != '0);
    res.top_key     = (count != '0) ? top_key_ext[31:0] : '0;
    res.top_value   = (count != '0) ? top_val : '0;
  end

endmodule

// ===== sv/binary_heap_priority_queue_top.sv =====
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: key_in, value_in, position
// m_*       out  m_tvalid/m_tready  tdata: status, out_key, out_value, entry_count,
//                                    top_valid, top_key, top_value
// min_first in   min_first_we       min_first_wdata (write only, no wait)
//
// insert climbs level by level from its new slot; update reads the stored value, then climbs;
// poll sinks the last entry from the root level by level (not when it was the only entry);
// a refused or unused request goes straight to the result; the steps run one at a time on one
// memory read port and one shared key comparator; s_tready is high only while idle, and the
// next request may enter while a stalled m_tready holds the result in the output register
// rst is synchronous: count clears, min_first returns to 1, the heap memory is kept
module binary_heap_priority_queue_top import hp_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         min_first_we,
  input  logic         min_first_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,  // mode
  input  logic [71:0]  s_tdata,  // key_in, value_in, position
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata   // status, out_key, out_value, entry_count,
                                 // top_valid, top_key, top_value
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  min_first;
  logic                  start, res_valid, res_take;
  logic [KEY_WIDTH+31:0] key_ext;
  hp_result_t            res;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [KEY_WIDTH-1:0] wkey, rkey;
  logic [FIELD_W-1:0]   wval, rval;

  always_ff @(posedge clk) begin
    if (rst) min_first <= 1'b1;
    else if (min_first_we) min_first <= min_first_wdata;
  end

  assign start   = s_tvalid && s_tready;
  assign key_ext = {{KEY_WIDTH{1'b0}}, s_tdata[31:0]};

  hp_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .min_first (min_first),
    .start     (start),
    .ready     (s_tready),
    .mode      (hp_mode_t'(s_tuser)),
    .key       (key_ext[KEY_WIDTH-1:0]),
    .value     (s_tdata[63:32]),
    .position  (s_tdata[69:64]),
    .we        (we),
    .waddr     (waddr),
    .wkey      (wkey),
    .wval      (wval),
    .raddr     (raddr),
    .rkey      (rkey),
    .rval      (rval),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  hp_ram #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .AW        (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wkey  (wkey),
    .wval  (wval),
    .raddr (raddr),
    .rkey  (rkey),
    .rval  (rval)
  );

  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {6'b0, res.top_value, res.top_key, res.top_valid, res.entry_count,
                  res.out_value, res.out_key, res.status};
    end
  end

endmodule

// ===== tb/binary_heap_priority_queue_top_test.sv =====
`timescale 1ns / 1ps

module binary_heap_priority_queue_top_test;
  import hp_pkg::*;

  localparam int HEAP_SLOTS = 64;
  localparam int CYCLE_LIMIT = 400000;

  class heap_tracker;
    logic [31:0] keys [HEAP_SLOTS];
    logic [31:0] vals [HEAP_SLOTS];
    int unsigned fill;
    bit smallest_on_top;
    hp_result_t expected_results[$];
    int errors;

    function new();
      fill = 0;
      smallest_on_top = 1;
      errors = 0;
    endfunction

    function bit ahead(logic [31:0] a, logic [31:0] b);
      return smallest_on_top ? (a < b) : (a > b);
    endfunction

    function void swap_slots(int a, int b);
      logic [31:0] k;
      logic [31:0] v;
      k = keys[a];
      v = vals[a];
      keys[a] = keys[b];
      vals[a] = vals[b];
      keys[b] = k;
      vals[b] = v;
    endfunction

    function void climb(int p);
      int up;
      while (p > 0) begin
        up = (p - 1) / 2;
        if (!ahead(keys[p], keys[up])) break;
        swap_slots(p, up);
        p = up;
      end
    endfunction

    // children tie: the left one wins, and only a strict gain moves the entry
    function void descend(int p);
      int l;
      int pick;
      while (1) begin
        l = 2 * p + 1;
        if (l >= fill) break;
        pick = l;
        if (l + 1 < fill && ahead(keys[l + 1], keys[l])) pick = l + 1;
        if (!ahead(keys[pick], keys[p])) break;
        swap_slots(p, pick);
        p = pick;
      end
    endfunction

    function void note_request(hp_mode_t mode, logic [31:0] key, logic [31:0] value,
                               logic [5:0] pos);
      hp_result_t r;
      r = '0;
      r.status = ST_OK;
      case (mode)
        MODE_INSERT: begin
          if (fill >= HEAP_SLOTS) begin
            r.status = ST_FULL;
          end else begin
            keys[fill] = key;
            vals[fill] = value;
            fill++;
            climb(fill - 1);
          end
        end
        MODE_POLL: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.out_key = keys[0];
            r.out_value = vals[0];
            fill--;
            keys[0] = keys[fill];
            vals[0] = vals[fill];
            descend(0);
          end
        end
        MODE_UPDATE: begin
          // new key only moves toward the root, even if it belongs lower
          if (pos >= fill) begin
            r.status = ST_RANGE;
          end else begin
            keys[pos] = key;
            climb(pos);
          end
        end
        default: ;
      endcase
      r.entry_count = 7'(fill);
      if (fill > 0) begin
        r.top_valid = 1'b1;
        r.top_key = keys[0];
        r.top_value = vals[0];
      end
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(logic [143:0] d);
      hp_result_t e;
      if (expected_results.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = expected_results.pop_front();
      compare_field("status", 32'(d[1:0]), 32'(e.status));
      compare_field("out_key", d[33:2], e.out_key);
      compare_field("out_value", d[65:34], e.out_value);
      compare_field("entry_count", 32'(d[72:66]), 32'(e.entry_count));
      compare_field("top_valid", 32'(d[73]), 32'(e.top_valid));
      compare_field("top_key", d[105:74], e.top_key);
      compare_field("top_value", d[137:106], e.top_value);
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         min_first_we;
  logic         min_first_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [1:0]   s_tuser;   // mode
  logic [71:0]  s_tdata;   // key_in, value_in, position
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;   // status, out_key, out_value, entry_count,
                           // top_valid, top_key, top_value

  heap_tracker sb;
  int accepted = 0;
  bit calm = 0;

  binary_heap_priority_queue_top DUT (
    .clk             (clk),
    .rst             (rst),
    .min_first_we    (min_first_we),
    .min_first_wdata (min_first_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tuser         (s_tuser),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("binary_heap_priority_queue_top_test: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (min_first_we) sb.smallest_on_top = min_first_wdata;
      if (s_tvalid && s_tready) begin
        sb.note_request(hp_mode_t'(s_tuser), s_tdata[31:0], s_tdata[63:32], s_tdata[69:64]);
        accepted++;
      end
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 7);
    if (r < 36) return 32'h0;
    if (r < 42) return 32'hFFFF_FFFF;
    if (r < 48) return $urandom_range(32'hFFFF_FFF8, 32'hFFFF_FFFF);
    return $urandom;
  endfunction

  // result side stalls
  initial begin
    int g;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        m_tready = 1'b0;
        repeat (g) @(negedge clk);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // valid stays high on return so a back-to-back request keeps it up
  task send_request(hp_mode_t mode, logic [31:0] key, logic [31:0] value, logic [5:0] pos);
    int gap;
    int target;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser = mode;
    s_tdata = {2'b00, pos, value, key};
    s_tvalid = 1'b1;
    target = accepted + 1;
    do @(negedge clk); while (accepted < target);
  endtask

  task settle();
    s_tvalid = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task write_order(bit smallest);
    settle();
    min_first_we = 1'b1;
    min_first_wdata = smallest;
    @(negedge clk);
    min_first_we = 1'b0;
  endtask

  task random_phase(int n, int ins_w, int poll_w, int upd_w);
    int r;
    hp_mode_t mode;
    logic [5:0] pos;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_w) mode = MODE_INSERT;
      else if (r < ins_w + poll_w) mode = MODE_POLL;
      else if (r < ins_w + poll_w + upd_w) mode = MODE_UPDATE;
      else mode = MODE_NONE;
      if (mode == MODE_UPDATE && sb.fill > 0 && $urandom_range(0, 9) < 8)
        pos = 6'($urandom_range(0, sb.fill - 1));
      else
        pos = 6'($urandom_range(0, 63));
      send_request(mode, pick_key(), $urandom, pos);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    min_first_we = 1'b0;
    min_first_wdata = 1'b0;
    s_tvalid = 1'b0;
    s_tuser = MODE_NONE;
    s_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_order(1'b1);
    // empty heap corner cases
    send_request(MODE_POLL, 32'h0, 32'h0, 6'd0);
    send_request(MODE_UPDATE, 32'h1234, 32'h0, 6'd0);
    send_request(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    // key and value extremes, then ties, then updates and polls that drain the heap
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h0, 6'd0);
    send_request(MODE_INSERT, 32'h0, 32'hFFFF_FFFF, 6'd0);
    send_request(MODE_INSERT, 32'd5, 32'h5555_5555, 6'd0);
    send_request(MODE_INSERT, 32'd5, 32'hAAAA_AAAA, 6'd0);
    send_request(MODE_INSERT, 32'd5, 32'd3, 6'd0);
    send_request(MODE_INSERT, 32'd5, 32'd4, 6'd0);
    send_request(MODE_UPDATE, 32'd1, 32'h0, 6'd63);
    send_request(MODE_UPDATE, 32'd0, 32'h0, 6'd3);
    send_request(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0, 6'd1);
    send_request(MODE_NONE, 32'h1, 32'h2, 6'd2);
    repeat (7) send_request(MODE_POLL, 32'h0, 32'h0, 6'd0);

    write_order(1'b0);
    random_phase(90, 85, 5, 8);
    random_phase(60, 10, 75, 12);
    write_order(1'b1);
    calm = 1'b1;
    random_phase(90, 85, 5, 8);
    calm = 1'b0;
    random_phase(100, 40, 35, 20);
    write_order(1'b0);
    random_phase(80, 20, 65, 12);
    write_order(1'b1);
    random_phase(80, 45, 40, 12);

    settle();
    repeat (30) @(negedge clk);
    if (sb.errors == 0) begin
      $display("binary_heap_priority_queue_top_test: PASS");
    end else begin
      $display("binary_heap_priority_queue_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== binary_heap_priority_queue_top.f =====
sv/hp_pkg.sv
sv/hp_ram.sv
sv/hp_ctrl.sv
sv/binary_heap_priority_queue_top.sv
tb/binary_heap_priority_queue_top_test.sv
